/* sv/rhpc_pkg.sv */
// Shared types and constants of the rolling hash pattern counter.
// Used by the divider, datapath, controller and top level; depends on nothing.
package rhpc_pkg;

  // Field and register widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DataW    = 64;
  localparam int unsigned LenW     = 5;
  localparam int unsigned ModW     = 16;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PatBytes = 16;
  localparam int unsigned PatIdxW  = 4;

  // Remainder unit: two quotient bits per cycle over a 24-bit dividend
  localparam int unsigned DivW     = ModW + ByteW;
  localparam int unsigned DivSteps = DivW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Register reset values
  localparam logic [LenW-1:0]  LenReset  = LenW'(6);
  localparam logic [ByteW-1:0] BaseReset = ByteW'(10);
  localparam logic [ModW-1:0]  ModReset  = ModW'(17);
  localparam logic [ModW-1:0]  MinMod    = ModW'(2);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_HASH_BASE      = 3'd3,
    REG_HASH_MODULUS   = 3'd4
  } reg_idx_e;

  // Operand selection of the shared multiply and reduce path
  typedef enum logic [2:0] {
    OP_PH   = 3'd0,  // pattern hash step: base * ph + pattern byte
    OP_BP   = 3'd1,  // leading power step: power * base
    OP_THM  = 3'd2,  // reduce the stored text hash
    OP_SUB  = 3'd3,  // outgoing byte times leading power
    OP_ROLL = 3'd4   // base * hash + new byte
  } div_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    j_inc;
    logic    shift;
    logic    eval;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic th_ge_md;
    logic roll;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/rhpc_div.sv */
// Iterative remainder unit: 24-bit dividend modulo a 16-bit divisor, two bits per cycle.
// Depends on rhpc_pkg.
module rhpc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rhpc_pkg::DivW-1:0]    dividend_i,
  input  logic [rhpc_pkg::ModW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [rhpc_pkg::ModW-1:0]    rem_o
);
  import rhpc_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [ModW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dvd_q, dvd_d;
  logic [ModW-1:0]    dsr_q, dsr_d;
  logic [ModW:0]      r1, r2;
  logic [ModW-1:0]    step_rem;

  // Two restoring steps; the partial remainder stays below the divisor
  always_comb begin
    r1 = {rem_q, dvd_q[DivW-1]};
    if (r1 >= {1'b0, dsr_q}) begin
      r1 = r1 - {1'b0, dsr_q};
    end
    r2 = {r1[ModW-1:0], dvd_q[DivW-2]};
    if (r2 >= {1'b0, dsr_q}) begin
      r2 = r2 - {1'b0, dsr_q};
    end
    step_rem = r2[ModW-1:0];
  end

  // Load on start, then advance until the count runs out
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d = DivCntW'(DivSteps);
      rem_d = '0;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DivCntW'(1);
      done_d = (cnt_q == DivCntW'(1));
      rem_d  = step_rem;
      dvd_d  = {dvd_q[DivW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* sv/rhpc_dp.sv */
// Datapath: configuration registers, byte window, hashes, match counter and result register.
// Depends on rhpc_pkg and rhpc_div.
module rhpc_dp #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rhpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rhpc_pkg::DataW-1:0]    cfg_data_i,
  input  logic [rhpc_pkg::ByteW-1:0]    text_byte_i,
  input  logic                          first_of_text_i,
  input  logic                          end_of_text_i,
  input  rhpc_pkg::cmd_t                cmd_i,
  output rhpc_pkg::sts_t                sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [rhpc_pkg::ModW-1:0]     window_hash_o,
  output logic                          window_full_o,
  output logic                          hash_hit_o,
  output logic                          match_found_o,
  output logic [rhpc_pkg::CntW-1:0]     match_total_o,
  output logic                          final_result_o
);
  import rhpc_pkg::*;

  localparam int unsigned     IdxW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned     SeenW  = $clog2(MAX_PATTERN + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  // Configuration registers
  logic [DataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]  pat_len_q;
  logic [ByteW-1:0] base_q;
  logic [ModW-1:0]  mod_q;

  // Per-text state
  logic [ByteW-1:0]   win_q [MAX_PATTERN];
  logic [SeenW-1:0]   seen_q, seen_d;
  logic [ModW-1:0]    th_q, th_d;
  logic [ModW-1:0]    ph_q, ph_d;
  logic [ModW-1:0]    lp_q, lp_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PatIdxW-1:0] j_q, j_d;
  logic [ByteW-1:0]   byte_q;
  logic               last_q;
  div_op_e            op_q;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [ModW-1:0]    wh_q;
  logic               full_q, hit_q, match_q, final_q;
  logic [CntW-1:0]    total_q;

  // Derived values
  logic [LenW-1:0]      m;
  logic [ModW-1:0]      md;
  logic [ByteW-1:0]     pat_b [PatBytes];
  logic [2*DataW-1:0]   pat_vec;
  logic [ByteW-1:0]     old_byte;
  logic [ModW-1:0]      mul_a;
  logic [ByteW-1:0]     mul_b, add_b;
  logic [DivW-1:0]      dvd;
  logic                 div_done;
  logic [ModW-1:0]      rem;
  logic [ModW:0]        diff;
  logic [ModW-1:0]      t_red;
  logic                 full, hit, mismatch, match;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LenReset;
      base_q     <= BaseReset;
      mod_q      <= ModReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        REG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        REG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[LenW-1:0];
        REG_HASH_BASE:      base_q     <= cfg_data_i[ByteW-1:0];
        REG_HASH_MODULUS:   mod_q      <= cfg_data_i[ModW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length and modulus into their working ranges
  always_comb begin
    m = pat_len_q;
    if (pat_len_q == '0) begin
      m = LenW'(1);
    end else if (pat_len_q > MaxLen) begin
      m = MaxLen;
    end
  end
  assign md = (mod_q < MinMod) ? MinMod : mod_q;

  // Split the pattern into bytes
  assign pat_vec = {pat_high_q, pat_low_q};
  for (genvar k = 0; k < PatBytes; k++) begin : g_pat
    assign pat_b[k] = pat_vec[ByteW*k +: ByteW];
  end

  assign old_byte = win_q[IdxW'(m - LenW'(1))];

  // Select operands of the shared multiply-add feeding the remainder unit
  always_comb begin
    mul_a = th_q;
    mul_b = ByteW'(1);
    add_b = '0;
    unique case (cmd_i.div_op)
      OP_PH: begin
        mul_a = ph_q;
        mul_b = base_q;
        add_b = pat_b[j_q];
      end
      OP_BP: begin
        mul_a = lp_q;
        mul_b = base_q;
      end
      OP_THM: begin
        mul_a = th_q;
      end
      OP_SUB: begin
        mul_a = lp_q;
        mul_b = old_byte;
      end
      OP_ROLL: begin
        mul_a = th_q;
        mul_b = base_q;
        add_b = byte_q;
      end
      default: ;
    endcase
  end
  assign dvd = ({{ByteW{1'b0}}, mul_a} * {{ModW{1'b0}}, mul_b}) + {{ModW{1'b0}}, add_b};

  rhpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (md),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // Remove the outgoing byte: hash + modulus - term, folded once
  always_comb begin
    diff = {1'b0, th_q} + {1'b0, md} - {1'b0, rem};
    if (diff >= {1'b0, md}) begin
      diff = diff - {1'b0, md};
    end
    t_red = diff[ModW-1:0];
  end

  // Compare the window with the pattern, oldest byte against pattern byte 0
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LenW'(i) < m) &&
          (win_q[i] != pat_b[PatIdxW'(m - LenW'(1) - LenW'(i))])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign full  = (LenW'(seen_q) >= m);
  assign hit   = full && (th_q == ph_q);
  assign match = hit && !mismatch;

  // Next state of hashes, counters and loop index
  always_comb begin
    seen_d = seen_q;
    th_d   = th_q;
    ph_d   = ph_q;
    lp_d   = lp_q;
    cnt_d  = cnt_q;
    j_d    = j_q;
    if (cmd_i.load) begin
      j_d = '0;
      if (first_of_text_i) begin
        seen_d = '0;
        th_d   = '0;
        ph_d   = '0;
        lp_d   = ModW'(1);
        cnt_d  = '0;
      end
    end
    if (div_done) begin
      unique case (op_q)
        OP_PH:   ph_d = rem;
        OP_BP:   lp_d = rem;
        OP_THM:  th_d = rem;
        OP_SUB:  th_d = t_red;
        OP_ROLL: th_d = rem;
        default: ;
      endcase
    end
    if (cmd_i.j_inc) begin
      j_d = j_q + PatIdxW'(1);
    end
    if (cmd_i.shift && (seen_q != SeenW'(MAX_PATTERN))) begin
      seen_d = seen_q + SeenW'(1);
    end
    if (cmd_i.eval && match && (cnt_q != '1)) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  // Hold a result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.eval) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      th_q        <= '0;
      ph_q        <= '0;
      lp_q        <= ModW'(1);
      cnt_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      th_q        <= th_d;
      ph_q        <= ph_d;
      lp_q        <= lp_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: transaction fields, operation tag, window and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= text_byte_i;
      last_q <= end_of_text_i;
    end
    if (cmd_i.div_start) begin
      op_q <= cmd_i.div_op;
    end
    if (cmd_i.shift) begin
      win_q[0] <= byte_q;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
    if (cmd_i.eval) begin
      wh_q    <= th_q;
      full_q  <= full;
      hit_q   <= hit;
      match_q <= match;
      total_q <= cnt_d;
      final_q <= last_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.th_ge_md = (th_q >= md);
  assign sts_o.roll     = full;
  assign sts_o.j_last   = ({1'b0, j_q} + LenW'(1)) >= m;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign window_hash_o  = wh_q;
  assign window_full_o  = full_q;
  assign hash_hit_o     = hit_q;
  assign match_found_o  = match_q;
  assign match_total_o  = total_q;
  assign final_result_o = final_q;

endmodule

/* sv/rhpc_ctrl.sv */
// Controller: sequences precompute, hash reduction, window shift and result load per byte.
// Depends on rhpc_pkg.
module rhpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            first_of_text_i,
  output logic            in_stall_o,
  input  rhpc_pkg::sts_t  sts_i,
  output rhpc_pkg::cmd_t  cmd_o
);
  import rhpc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_PH     = 13'h0002,
    S_PH_W   = 13'h0004,
    S_BP     = 13'h0008,
    S_BP_W   = 13'h0010,
    S_THM    = 13'h0020,
    S_THM_W  = 13'h0040,
    S_SUB    = 13'h0080,
    S_SUB_W  = 13'h0100,
    S_ROLL   = 13'h0200,
    S_ROLL_W = 13'h0400,
    S_SHIFT  = 13'h0800,
    S_EVAL   = 13'h1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.div_op    = OP_THM;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = first_of_text_i ? S_PH : S_THM;
        end
      end
      S_PH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = OP_PH;
        state_d         = S_PH_W;
      end
      S_PH_W: begin
        if (sts_i.div_done) begin
          state_d = sts_i.j_last ? S_THM : S_BP;
        end
      end
      S_BP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = OP_BP;
        state_d         = S_BP_W;
      end
      S_BP_W: begin
        if (sts_i.div_done) begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_PH;
        end
      end
      S_THM: begin
        // Reduce only a hash left at or above a lowered modulus
        if (sts_i.th_ge_md) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_THM;
          state_d         = S_THM_W;
        end else begin
          state_d = S_SUB;
        end
      end
      S_THM_W: begin
        if (sts_i.div_done) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        if (sts_i.roll) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = OP_SUB;
          state_d         = S_SUB_W;
        end else begin
          state_d = S_ROLL;
        end
      end
      S_SUB_W: begin
        if (sts_i.div_done) begin
          state_d = S_ROLL;
        end
      end
      S_ROLL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = OP_ROLL;
        state_d         = S_ROLL_W;
      end
      S_ROLL_W: begin
        if (sts_i.div_done) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        // Wait for room in the result register
        if (sts_i.out_free) begin
          cmd_o.eval = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* sv/rolling_hash_pattern_counter_core.sv */
// Top level of the rolling hash pattern counter: controller, datapath and port wiring.
// Depends on rhpc_pkg, rhpc_ctrl and rhpc_dp.
//
// Usage: text bytes enter on the in channel (in_valid_i / in_stall_o), one per
// transaction, with first_of_text_i on the first byte of a text and
// end_of_text_i on the last. Each byte gives one result on the out channel
// (out_valid_o / out_stall_i): window hash, full, hit and match flags, the
// running match total and the end-of-text echo. Registers are written on the
// cfg port (cfg_we_i, cfg_index_i, cfg_data_i) while no byte is in flight.
// Bytes are processed one at a time: each modulo reduction runs in the shared
// two-bit-per-cycle remainder unit, and a byte needs two of them (one while
// filling), plus one more for a hash left at or above a modulus lowered
// mid-text. A first byte also computes the pattern hash and leading power.
// Reset restores the register defaults and clears hash state, count and the
// result valid flag. A stalled result waits in its register; the next byte is
// still taken and processed, and stops only at its own result load.
module rolling_hash_pattern_counter_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rhpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rhpc_pkg::DataW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rhpc_pkg::ByteW-1:0]    text_byte_i,
  input  logic                          first_of_text_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rhpc_pkg::ModW-1:0]     window_hash_o,
  output logic                          window_full_o,
  output logic                          hash_hit_o,
  output logic                          match_found_o,
  output logic [rhpc_pkg::CntW-1:0]     match_total_o,
  output logic                          final_result_o
);
  import rhpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rhpc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .first_of_text_i (first_of_text_i),
    .in_stall_o      (in_stall_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  rhpc_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .text_byte_i     (text_byte_i),
    .first_of_text_i (first_of_text_i),
    .end_of_text_i   (end_of_text_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .window_hash_o   (window_hash_o),
    .window_full_o   (window_full_o),
    .hash_hit_o      (hash_hit_o),
    .match_found_o   (match_found_o),
    .match_total_o   (match_total_o),
    .final_result_o  (final_result_o)
  );

endmodule

/* sv/rhpc_chk.sv */
// Port-level checker of the rolling hash pattern counter, bound to the top level.
// Depends on rhpc_pkg and rolling_hash_pattern_counter_core.
module rhpc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rhpc_pkg::ModW-1:0]     window_hash_o,
  input logic                          window_full_o,
  input logic                          hash_hit_o,
  input logic                          match_found_o,
  input logic [rhpc_pkg::CntW-1:0]     match_total_o,
  input logic                          final_result_o
);
  import rhpc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_hash_o) &&
      $stable(match_total_o) && $stable(match_found_o) && $stable(final_result_o))
    else $error("stalled result changed or dropped");

  // Keep the flags nested: match needs a hit, a hit needs a full window
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hash_hit_o || window_full_o) && (!match_found_o || hash_hit_o))
    else $error("result flags inconsistent");

  // Take one byte at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("byte accepted while previous one in progress");

  // Never show a fresh result in the cycle after a byte is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind rolling_hash_pattern_counter_core rhpc_chk u_rhpc_chk (.*);
